[hw/rtl/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg: shared codes for the due-time priority task queue
// Request codes, result status codes and the per-cell operation code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

	localparam int REQ_W    = 3;
	localparam int STATUS_W = 3;
	localparam int KIND_W   = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_SCHED  = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_FLUSH  = 3'd2,
		REQ_POP    = 3'd3,
		REQ_PEEK   = 3'd4
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_BUSY     = 3'd1,
		ST_DUP      = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_NOTDUE   = 3'd5,
		ST_NOTFOUND = 3'd6
	} status_t;

	// Operation broadcast to every cell of the chain
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_FLUSH  = 2'd3
	} cell_op_t;

endpackage

`default_nettype wire

[hw/rtl/dtq_req_if.sv]
// ----------------------------------------------------------------------------
// dtq_req_if: request channel of the task queue
// Valid/ready channel carrying one request per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dtq_req_if #(
	parameter int TIME_BITS = 32,
	parameter int ZONE_BITS = 8
);
	logic                          valid;
	logic                          ready;
	logic [dtq_pkg::REQ_W-1:0]     req_type;
	logic [ZONE_BITS-1:0]          zone_id;
	logic [TIME_BITS-1:0]          due_time;
	logic [dtq_pkg::KIND_W-1:0]    task_kind;
	logic                          zone_busy;
	logic [TIME_BITS-1:0]          current_time;

	modport source (
		output valid, req_type, zone_id, due_time, task_kind, zone_busy, current_time,
		input  ready
	);
	modport sink (
		input  valid, req_type, zone_id, due_time, task_kind, zone_busy, current_time,
		output ready
	);
endinterface

`default_nettype wire

[hw/rtl/dtq_rsp_if.sv]
// ----------------------------------------------------------------------------
// dtq_rsp_if: result channel of the task queue
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dtq_rsp_if #(
	parameter int TIME_BITS = 32,
	parameter int ZONE_BITS = 8
);
	logic                          valid;
	logic                          ready;
	logic [dtq_pkg::STATUS_W-1:0]  status;
	logic                          entry_valid;
	logic [ZONE_BITS-1:0]          out_zone_id;
	logic [TIME_BITS-1:0]          out_due_time;
	logic [dtq_pkg::KIND_W-1:0]    out_task_kind;
	logic                          out_flush;

	modport source (
		output valid, status, entry_valid, out_zone_id, out_due_time, out_task_kind,
		       out_flush,
		input  ready
	);
	modport sink (
		input  valid, status, entry_valid, out_zone_id, out_due_time, out_task_kind,
		       out_flush,
		output ready
	);
endinterface

`default_nettype wire

[hw/rtl/dtq_cell.sv]
// ----------------------------------------------------------------------------
// dtq_cell: one slot of the sorted task chain
// Holds one entry, decides locally whether a new entry lands here, whether
// the entry shifts toward the head on removal, and compares its zone.
// The chain is kept in due time order, then zone id; the flush mark rides
// along with the entry and does not move it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtq_cell #(
	parameter int TIME_BITS = 32,
	parameter int ZONE_BITS = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  dtq_pkg::cell_op_t            op,
	// entry offered for insertion
	input  wire [TIME_BITS-1:0]          new_due,
	input  wire [ZONE_BITS-1:0]          new_zone,
	input  wire [dtq_pkg::KIND_W-1:0]    new_kind,
	// key of the entry being removed
	input  wire [TIME_BITS-1:0]          ref_due,
	input  wire [ZONE_BITS-1:0]          ref_zone,
	// zone lookup
	input  wire [ZONE_BITS-1:0]          key_zone,
	output logic                         zone_hit,
	// neighbor toward the head
	input  wire                          prev_ins,
	input  wire                          prev_used,
	input  wire                          prev_flush,
	input  wire [TIME_BITS-1:0]          prev_due,
	input  wire [ZONE_BITS-1:0]          prev_zone,
	input  wire [dtq_pkg::KIND_W-1:0]    prev_kind,
	// neighbor toward the tail
	input  wire                          next_used,
	input  wire                          next_flush,
	input  wire [TIME_BITS-1:0]          next_due,
	input  wire [ZONE_BITS-1:0]          next_zone,
	input  wire [dtq_pkg::KIND_W-1:0]    next_kind,
	// own entry and insertion flag to the tail neighbor
	output logic                         ins,
	output logic                         used,
	output logic                         flush,
	output logic [TIME_BITS-1:0]         due,
	output logic [ZONE_BITS-1:0]         zone,
	output logic [dtq_pkg::KIND_W-1:0]   kind
);
	import dtq_pkg::*;

	logic                 used_q;
	logic                 flush_q;
	logic [TIME_BITS-1:0] due_q;
	logic [ZONE_BITS-1:0] zone_q;
	logic [KIND_W-1:0]    kind_q;
	logic                 rm_here;

	// New entry goes ahead of this one by due time and zone, or the slot is free
	assign ins = !used_q || (new_due < due_q) ||
		((new_due == due_q) && (new_zone < zone_q));

	// This entry is at or behind the removed key: shift it toward the head
	assign rm_here = used_q && !((due_q < ref_due) ||
		((due_q == ref_due) && (zone_q < ref_zone)));

	assign zone_hit = used_q && (zone_q == key_zone);

	// Hold control bits of the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			flush_q <= 1'b0;
		end else begin
			unique case (op)
				OP_INSERT: begin
					if (ins) begin
						used_q  <= prev_ins ? prev_used  : 1'b1;
						flush_q <= prev_ins ? prev_flush : 1'b0;
					end
				end
				OP_REMOVE: begin
					if (rm_here) begin
						used_q  <= next_used;
						flush_q <= next_flush;
					end
				end
				OP_FLUSH: flush_q <= flush_q | used_q;
				default: ;
			endcase
		end
	end

	// Hold payload of the slot
	always_ff @(posedge clk) begin
		if (op == OP_INSERT && ins) begin
			due_q  <= prev_ins ? prev_due  : new_due;
			zone_q <= prev_ins ? prev_zone : new_zone;
			kind_q <= prev_ins ? prev_kind : new_kind;
		end else if (op == OP_REMOVE && rm_here) begin
			due_q  <= next_due;
			zone_q <= next_zone;
			kind_q <= next_kind;
		end
	end

	assign used  = used_q;
	assign flush = flush_q;
	assign due   = due_q;
	assign zone  = zone_q;
	assign kind  = kind_q;

endmodule

`default_nettype wire

[hw/rtl/due_time_priority_task_queue.sv]
// ----------------------------------------------------------------------------
// due_time_priority_task_queue: sorted chain of pending zone tasks
// Cells stay ordered by due time, then zone id. The head of the queue is the
// first flushed cell, or the first cell when no entry is flushed.
//
//   channel  dir  payload
//   req      in   req_type, zone_id, due_time, task_kind, zone_busy,
//                 current_time
//   rsp      out  status, entry_valid, out_zone_id, out_due_time,
//                 out_task_kind, out_flush
//
// Each request has a lookup cycle on transfer (zone compare in every
// cell) and an apply cycle that picks the head and updates the chain
// in one step, every cell choosing its own value from its neighbors.
// One request is in work at a time; the result register frees the request
// side, so a new request is taken while a result waits.
// A stalled result holds the apply cycle until the result register drains.
// Reset empties the chain at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module due_time_priority_task_queue #(
	parameter int CAPACITY  = 16,
	parameter int TIME_BITS = 32,
	parameter int ZONE_BITS = 8
) (
	input  wire       clk,
	input  wire       arst_n,
	dtq_req_if.sink   req,
	dtq_rsp_if.source rsp
);
	import dtq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_APPLY
	} state_t;

	state_t state_q;

	// Chain wires
	logic                 ins_w   [CAPACITY];
	logic                 used_w  [CAPACITY];
	logic                 flush_w [CAPACITY];
	logic [TIME_BITS-1:0] due_w   [CAPACITY];
	logic [ZONE_BITS-1:0] zone_w  [CAPACITY];
	logic [KIND_W-1:0]    kind_w  [CAPACITY];
	logic [CAPACITY-1:0]  hit_w;
	logic [CAPACITY-1:0]  used_vec;

	// Captured request and lookup results
	logic [REQ_W-1:0]     req_s1;
	logic [ZONE_BITS-1:0] zone_s1;
	logic [TIME_BITS-1:0] due_s1;
	logic [KIND_W-1:0]    kind_s1;
	logic                 busy_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 hit_s1;
	logic                 hit_flush_s1;
	logic [TIME_BITS-1:0] hit_due_s1;
	logic [KIND_W-1:0]    hit_kind_s1;
	logic                 empty_s1;
	logic                 full_s1;

	// Lookup results from the chain
	logic                 hit_any;
	logic                 hit_flush;
	logic [TIME_BITS-1:0] hit_due;
	logic [KIND_W-1:0]    hit_kind;

	// Head of the queue
	logic                 head_flush;
	logic [TIME_BITS-1:0] head_due;
	logic [ZONE_BITS-1:0] head_zone;
	logic [KIND_W-1:0]    head_kind;

	// Apply cycle decisions
	cell_op_t             op_c;
	cell_op_t             op;
	status_t              status_c;
	logic                 report_c;
	logic                 rep_flush_c;
	logic [TIME_BITS-1:0] rep_due_c;
	logic [ZONE_BITS-1:0] rep_zone_c;
	logic [KIND_W-1:0]    rep_kind_c;
	logic                 out_free;
	logic                 fire;
	logic                 take;

	// Result register
	logic                 rsp_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 entry_valid_q;
	logic [ZONE_BITS-1:0] out_zone_q;
	logic [TIME_BITS-1:0] out_due_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic                 out_flush_q;

	assign req.ready = (state_q == S_IDLE);
	assign take      = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fire      = (state_q == S_APPLY) && out_free;
	assign op        = fire ? op_c : OP_HOLD;

	// Build the chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                 p_ins;
		logic                 p_used;
		logic                 p_flush;
		logic [TIME_BITS-1:0] p_due;
		logic [ZONE_BITS-1:0] p_zone;
		logic [KIND_W-1:0]    p_kind;
		logic                 n_used;
		logic                 n_flush;
		logic [TIME_BITS-1:0] n_due;
		logic [ZONE_BITS-1:0] n_zone;
		logic [KIND_W-1:0]    n_kind;

		if (i == 0) begin : g_head
			assign p_ins   = 1'b0;
			assign p_used  = 1'b0;
			assign p_flush = 1'b0;
			assign p_due   = '0;
			assign p_zone  = '0;
			assign p_kind  = '0;
		end else begin : g_mid
			assign p_ins   = ins_w[i-1];
			assign p_used  = used_w[i-1];
			assign p_flush = flush_w[i-1];
			assign p_due   = due_w[i-1];
			assign p_zone  = zone_w[i-1];
			assign p_kind  = kind_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign n_used  = 1'b0;
			assign n_flush = 1'b0;
			assign n_due   = '0;
			assign n_zone  = '0;
			assign n_kind  = '0;
		end else begin : g_body
			assign n_used  = used_w[i+1];
			assign n_flush = flush_w[i+1];
			assign n_due   = due_w[i+1];
			assign n_zone  = zone_w[i+1];
			assign n_kind  = kind_w[i+1];
		end

		dtq_cell #(
			.TIME_BITS(TIME_BITS),
			.ZONE_BITS(ZONE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.new_due    (due_s1),
			.new_zone   (zone_s1),
			.new_kind   (kind_s1),
			.ref_due    (rep_due_c),
			.ref_zone   (rep_zone_c),
			.key_zone   (req.zone_id),
			.zone_hit   (hit_w[i]),
			.prev_ins   (p_ins),
			.prev_used  (p_used),
			.prev_flush (p_flush),
			.prev_due   (p_due),
			.prev_zone  (p_zone),
			.prev_kind  (p_kind),
			.next_used  (n_used),
			.next_flush (n_flush),
			.next_due   (n_due),
			.next_zone  (n_zone),
			.next_kind  (n_kind),
			.ins        (ins_w[i]),
			.used       (used_w[i]),
			.flush      (flush_w[i]),
			.due        (due_w[i]),
			.zone       (zone_w[i]),
			.kind       (kind_w[i])
		);

		assign used_vec[i] = used_w[i];
	end

	// Select the entry whose zone matched (at most one)
	always_comb begin
		hit_any   = 1'b0;
		hit_flush = 1'b0;
		hit_due   = '0;
		hit_kind  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_any   = hit_any | hit_w[i];
			hit_flush = hit_flush | (hit_w[i] & flush_w[i]);
			hit_due   = hit_due | (hit_w[i] ? due_w[i] : '0);
			hit_kind  = hit_kind | (hit_w[i] ? kind_w[i] : '0);
		end
	end

	// Pick the head: first flushed cell, else the first cell
	always_comb begin
		head_flush = flush_w[0];
		head_due   = due_w[0];
		head_zone  = zone_w[0];
		head_kind  = kind_w[0];
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (used_w[i] && flush_w[i]) begin
				head_flush = 1'b1;
				head_due   = due_w[i];
				head_zone  = zone_w[i];
				head_kind  = kind_w[i];
			end
		end
	end

	// Capture request and lookup on transfer
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1       <= req.req_type;
			zone_s1      <= req.zone_id;
			due_s1       <= req.due_time;
			kind_s1      <= req.task_kind;
			busy_s1      <= req.zone_busy;
			now_s1       <= req.current_time;
			hit_s1       <= hit_any;
			hit_flush_s1 <= hit_flush;
			hit_due_s1   <= hit_due;
			hit_kind_s1  <= hit_kind;
			empty_s1     <= !used_w[0];
			full_s1      <= used_w[CAPACITY-1];
		end
	end

	// Decide status, reported entry and chain operation
	always_comb begin
		op_c        = OP_HOLD;
		status_c    = ST_OK;
		report_c    = 1'b0;
		rep_flush_c = head_flush;
		rep_due_c   = head_due;
		rep_zone_c  = head_zone;
		rep_kind_c  = head_kind;
		unique case (req_s1)
			REQ_SCHED: begin
				priority if (busy_s1) status_c = ST_BUSY;
				else if (hit_s1)      status_c = ST_DUP;
				else if (full_s1)     status_c = ST_FULL;
				else                  op_c     = OP_INSERT;
			end
			REQ_DELETE: begin
				rep_flush_c = hit_flush_s1;
				rep_due_c   = hit_due_s1;
				rep_zone_c  = zone_s1;
				rep_kind_c  = hit_kind_s1;
				if (hit_s1) begin
					report_c = 1'b1;
					op_c     = OP_REMOVE;
				end else begin
					status_c = ST_NOTFOUND;
				end
			end
			REQ_FLUSH: op_c = OP_FLUSH;
			REQ_POP: begin
				priority if (empty_s1)                    status_c = ST_EMPTY;
				else if (!head_flush && head_due > now_s1) status_c = ST_NOTDUE;
				else begin
					report_c = 1'b1;
					op_c     = OP_REMOVE;
				end
			end
			REQ_PEEK: begin
				if (empty_s1) status_c = ST_EMPTY;
				else          report_c = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequence lookup and apply, hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Load result payload, zero entry fields when nothing is reported
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_c;
			entry_valid_q <= report_c;
			out_zone_q    <= report_c ? rep_zone_c  : '0;
			out_due_q     <= report_c ? rep_due_c   : '0;
			out_kind_q    <= report_c ? rep_kind_c  : '0;
			out_flush_q   <= report_c ? rep_flush_c : 1'b0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.entry_valid   = entry_valid_q;
	assign rsp.out_zone_id   = out_zone_q;
	assign rsp.out_due_time  = out_due_q;
	assign rsp.out_task_kind = out_kind_q;
	assign rsp.out_flush     = out_flush_q;

`ifndef SYNTH
	// Used slots stay packed toward the head
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((used_vec + 1'b1) & used_vec) == '0)
		else $error("chain has a hole");

	// Zones are unique in the chain
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_w))
		else $error("zone held in more than one cell");

	// Insert grows the chain by one entry
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_INSERT) |=> $countones(used_vec) == $past($countones(used_vec)) + 1)
		else $error("insert did not add one entry");

	// Remove shrinks the chain by one entry
	a_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_REMOVE) |=> $countones(used_vec) + 1 == $past($countones(used_vec)))
		else $error("remove did not drop one entry");

	// A new result only comes from the apply cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_APPLY))
		else $error("result without apply cycle");
`endif

endmodule

`default_nettype wire

[tb/tb_due_time_priority_task_queue.sv]
// ----------------------------------------------------------------------------
// tb_due_time_priority_task_queue: self-checking bench for the task queue
// Sends a short table of directed requests, then random request streams
// biased toward filling and draining the store. Every request transfer is
// predicted by a model of the slot store kept in the bench. Every result
// transfer is compared field by field with the oldest prediction. The sender
// idles in bursts. The receiver stalls on a rotating pattern, with one long
// hold-off, and the sender pauses once to let the queue drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_due_time_priority_task_queue;

	import dtq_pkg::*;

	localparam int CAPACITY  = 16;
	localparam int TIME_BITS = 32;
	localparam int ZONE_BITS = 8;

	// Request codes the block accepts but does nothing with
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	localparam int NUM_DIRECTED = 26;
	localparam int NUM_RANDOM   = 800;
	localparam int NUM_TOTAL    = NUM_DIRECTED + NUM_RANDOM;
	localparam int HOLD_AT      = NUM_DIRECTED + 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int PAUSE_AT     = NUM_DIRECTED + 450;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_PRINTED  = 40;

	typedef struct packed {
		logic [REQ_W-1:0]     op;
		logic [ZONE_BITS-1:0] zone;
		logic [TIME_BITS-1:0] due;
		logic [KIND_W-1:0]    kind;
		logic                 busy;
		logic [TIME_BITS-1:0] now;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic                 hit;
		logic [ZONE_BITS-1:0] zone;
		logic [TIME_BITS-1:0] due;
		logic [KIND_W-1:0]    kind;
		logic                 flushed;
	} rsp_item_t;

	typedef struct packed {
		req_item_t item;
		logic      fixed;
		rsp_item_t want;
	} plan_row_t;

	// Directed requests; the result is given only where it is plain to see
	localparam plan_row_t PLAN [NUM_DIRECTED] = '{
		// empty store: peek, pop, delete and flush
		'{'{REQ_PEEK, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_EMPTY, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_POP, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'hFFFF_FFFF}, 1'b1,
			'{ST_EMPTY, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_DELETE, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_NOTFOUND, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_FLUSH, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		// busy zone, extremes of zone and due time, duplicate, busy over duplicate
		'{'{REQ_SCHED, 8'h55, 32'h0000_0010, 3'd1, 1'b1, 32'h0000_0000}, 1'b1,
			'{ST_BUSY, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_SCHED, 8'hFF, 32'hFFFF_FFFF, 3'd7, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_SCHED, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'hFFFF_FFFF}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_SCHED, 8'hFF, 32'h0000_1234, 3'd1, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_DUP, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_SCHED, 8'h00, 32'h0000_0005, 3'd2, 1'b1, 32'h0000_0000}, 1'b1,
			'{ST_BUSY, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		// head is the earliest due time; pop at the exact due time
		'{'{REQ_PEEK, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b1, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_POP, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b1, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		// not due one time step early, due at the top of the time range
		'{'{REQ_POP, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'hFFFF_FFFE}, 1'b1,
			'{ST_NOTDUE, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_POP, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'hFFFF_FFFF}, 1'b1,
			'{ST_OK, 1'b1, 8'hFF, 32'hFFFF_FFFF, 3'd7, 1'b0}},
		// equal due times order by zone id
		'{'{REQ_SCHED, 8'hAA, 32'h0000_0064, 3'd5, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_SCHED, 8'h0F, 32'h0000_0064, 3'd2, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_SCHED, 8'h10, 32'h0000_0032, 3'd3, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_PEEK, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b0, '0},
		// flushed entries go ahead of a later, earlier-due entry
		'{'{REQ_FLUSH, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_SCHED, 8'h20, 32'h0000_0001, 3'd6, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_POP, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b0, '0},
		'{'{REQ_DELETE, 8'h0F, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b0, '0},
		// spare request codes leave the store alone
		'{'{REQ_SPARE_LO, 8'hFF, 32'hFFFF_FFFF, 3'd7, 1'b1, 32'hFFFF_FFFF}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_SPARE_MID, 8'h20, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_SPARE_HI, 8'hAA, 32'h0000_0064, 3'd5, 1'b0, 32'hFFFF_FFFF}, 1'b1,
			'{ST_OK, 1'b0, 8'h00, 32'h0000_0000, 3'd0, 1'b0}},
		'{'{REQ_POP, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b0, '0},
		'{'{REQ_PEEK, 8'h00, 32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000}, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	dtq_req_if #(.TIME_BITS(TIME_BITS), .ZONE_BITS(ZONE_BITS)) req_bus ();
	dtq_rsp_if #(.TIME_BITS(TIME_BITS), .ZONE_BITS(ZONE_BITS)) rsp_bus ();

	due_time_priority_task_queue #(
		.CAPACITY (CAPACITY),
		.TIME_BITS(TIME_BITS),
		.ZONE_BITS(ZONE_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus.sink),
		.rsp   (rsp_bus.source)
	);

	// Slot store of the queue as the bench sees it
	logic                 slot_live    [CAPACITY];
	logic                 slot_flushed [CAPACITY];
	logic [TIME_BITS-1:0] slot_due     [CAPACITY];
	logic [ZONE_BITS-1:0] slot_zone    [CAPACITY];
	logic [KIND_W-1:0]    slot_kind    [CAPACITY];

	rsp_item_t pending_results [$];

	int          mismatch_cnt;
	int          sent_cnt;
	int          rsp_cnt;
	int unsigned cycle_cnt;
	bit          stim_done;
	logic        hold_kick;

	// Random stream shaping
	logic [TIME_BITS-1:0] clock_now;
	int unsigned          sched_pct;
	int unsigned          random_built;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		if (mismatch_cnt < MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("result %0d %s got %h want %h",
				rsp_cnt, name, got, want));
	endtask

	function automatic int find_zone(input logic [ZONE_BITS-1:0] zone);
		for (int i = 0; i < CAPACITY; i++)
			if (slot_live[i] && slot_zone[i] == zone)
				return i;
		return -1;
	endfunction

	// Head of the order: flushed first, then earliest due, then lowest zone
	function automatic int head_slot();
		int best;
		best = -1;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!slot_live[i])
				continue;
			if (best < 0)
				best = i;
			else if (slot_flushed[i] != slot_flushed[best])
				best = slot_flushed[i] ? i : best;
			else if (slot_due[i] != slot_due[best])
				best = (slot_due[i] < slot_due[best]) ? i : best;
			else if (slot_zone[i] < slot_zone[best])
				best = i;
		end
		return best;
	endfunction

	function automatic rsp_item_t entry_of(input int s);
		rsp_item_t res;
		res = '0;
		res.status  = ST_OK;
		res.hit     = 1'b1;
		res.zone    = slot_zone[s];
		res.due     = slot_due[s];
		res.kind    = slot_kind[s];
		res.flushed = slot_flushed[s];
		return res;
	endfunction

	// Apply one request to the slot store and return its result
	function automatic rsp_item_t apply_request(input req_item_t r);
		rsp_item_t res;
		int        s;
		res = '0;
		res.status = ST_OK;
		case (r.op)
			REQ_SCHED: begin
				s = -1;
				for (int i = CAPACITY - 1; i >= 0; i--)
					if (!slot_live[i])
						s = i;
				if (r.busy)
					res.status = ST_BUSY;
				else if (find_zone(r.zone) >= 0)
					res.status = ST_DUP;
				else if (s < 0)
					res.status = ST_FULL;
				else begin
					slot_live[s]    = 1'b1;
					slot_flushed[s] = 1'b0;
					slot_due[s]     = r.due;
					slot_zone[s]    = r.zone;
					slot_kind[s]    = r.kind;
				end
			end
			REQ_DELETE: begin
				s = find_zone(r.zone);
				if (s < 0)
					res.status = ST_NOTFOUND;
				else begin
					res = entry_of(s);
					slot_live[s]    = 1'b0;
					slot_flushed[s] = 1'b0;
				end
			end
			REQ_FLUSH: begin
				for (int i = 0; i < CAPACITY; i++)
					if (slot_live[i])
						slot_flushed[i] = 1'b1;
			end
			REQ_POP: begin
				s = head_slot();
				if (s < 0)
					res.status = ST_EMPTY;
				else if (!slot_flushed[s] && slot_due[s] > r.now)
					res.status = ST_NOTDUE;
				else begin
					res = entry_of(s);
					slot_live[s]    = 1'b0;
					slot_flushed[s] = 1'b0;
				end
			end
			REQ_PEEK: begin
				s = head_slot();
				if (s < 0)
					res.status = ST_EMPTY;
				else
					res = entry_of(s);
			end
			default: ;
		endcase
		return res;
	endfunction

	// Draw a random request; phases drawn at random lean toward filling or draining
	function automatic req_item_t make_random_item();
		req_item_t   r;
		int unsigned pick;
		int unsigned start;
		if (random_built % 50 == 0)
			case ($urandom_range(0, 2))
				0: sched_pct = 75;
				1: sched_pct = 40;
				default: sched_pct = 15;
			endcase
		random_built++;

		pick = $urandom_range(0, 99);
		if (pick < sched_pct)
			r.op = REQ_SCHED;
		else begin
			pick = $urandom_range(0, 99);
			if (pick < 32)
				r.op = REQ_DELETE;
			else if (pick < 65)
				r.op = REQ_POP;
			else if (pick < 85)
				r.op = REQ_PEEK;
			else if (pick < 94)
				r.op = REQ_FLUSH;
			else
				r.op = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end

		// small zone pool makes duplicates likely; full range covers all bits
		r.zone = ZONE_BITS'(($urandom_range(0, 9) < 6) ?
			$urandom_range(0, 23) : $urandom_range(0, 255));
		if (r.op == REQ_DELETE && $urandom_range(0, 9) < 7) begin
			start = $urandom_range(0, CAPACITY - 1);
			for (int i = 0; i < CAPACITY; i++)
				if (slot_live[(start + i) % CAPACITY]) begin
					r.zone = slot_zone[(start + i) % CAPACITY];
					break;
				end
		end

		r.due  = ($urandom_range(0, 4) == 0) ? $urandom : clock_now + $urandom_range(0, 30);
		r.kind = KIND_W'($urandom_range(0, 7));
		r.busy = ($urandom_range(0, 9) == 0);
		clock_now += $urandom_range(0, 3);
		r.now  = ($urandom_range(0, 6) == 0) ? $urandom : clock_now;
		return r;
	endfunction

	// Request side: predict each transfer, then offer the next request
	always @(posedge clk) begin
		req_item_t   nxt;
		rsp_item_t   predicted;
		bit          offer;
		static req_item_t   cur_item;
		static logic        cur_fixed;
		static rsp_item_t   cur_want;
		static int unsigned burst_left = 1;
		static int unsigned gap_left   = 0;
		if (arst_n && !stim_done) begin
			offer = req_bus.valid;
			if (req_bus.valid && req_bus.ready) begin
				predicted = apply_request(cur_item);
				pending_results.push_back(cur_fixed ? cur_want : predicted);
				sent_cnt++;
				offer = 1'b0;
				if (sent_cnt == HOLD_AT)
					hold_kick <= 1'b1;
			end
			if (!offer) begin
				if (sent_cnt == NUM_TOTAL)
					stim_done = 1'b1;
				else if (sent_cnt == PAUSE_AT && pending_results.size() != 0)
					offer = 1'b0;
				else if (gap_left != 0)
					gap_left--;
				else begin
					if (sent_cnt < NUM_DIRECTED) begin
						nxt       = PLAN[sent_cnt].item;
						cur_fixed = PLAN[sent_cnt].fixed;
						cur_want  = PLAN[sent_cnt].want;
					end else begin
						nxt       = make_random_item();
						cur_fixed = 1'b0;
						cur_want  = '0;
					end
					cur_item = nxt;
					offer    = 1'b1;
					req_bus.req_type     <= nxt.op;
					req_bus.zone_id      <= nxt.zone;
					req_bus.due_time     <= nxt.due;
					req_bus.task_kind    <= nxt.kind;
					req_bus.zone_busy    <= nxt.busy;
					req_bus.current_time <= nxt.now;
					// start a new burst once this one is spent
					burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				req_bus.valid <= offer;
			end
		end
	end

	// Result side: check each transfer, then pick ready for the next cycle
	always @(posedge clk) begin
		rsp_item_t got;
		rsp_item_t want;
		logic      take;
		static logic [15:0] stall_pat = 16'hFFFF;
		static int unsigned pat_age   = 0;
		static int unsigned hold_left = 0;
		static bit          hold_used = 1'b0;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.status  = rsp_bus.status;
				got.hit     = rsp_bus.entry_valid;
				got.zone    = rsp_bus.out_zone_id;
				got.due     = rsp_bus.out_due_time;
				got.kind    = rsp_bus.out_task_kind;
				got.flushed = rsp_bus.out_flush;
				if (pending_results.size() == 0)
					flag_mismatch($sformatf("result %0d arrived with none pending", rsp_cnt));
				else begin
					want = pending_results.pop_front();
					check_field("status", 32'(got.status), 32'(want.status));
					check_field("entry_valid", 32'(got.hit), 32'(want.hit));
					check_field("out_zone_id", 32'(got.zone), 32'(want.zone));
					check_field("out_due_time", 32'(got.due), 32'(want.due));
					check_field("out_task_kind", 32'(got.kind), 32'(want.kind));
					check_field("out_flush", 32'(got.flushed), 32'(want.flushed));
				end
				rsp_cnt++;
			end
			// hold off once for a long stretch so the block backs up
			if (hold_left != 0) begin
				hold_left--;
				take = 1'b0;
			end else if (hold_kick && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				take      = 1'b0;
			end else begin
				if (pat_age == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pat = 16'hFFFF;
						1: stall_pat = 16'($urandom);
						2: stall_pat = 16'($urandom | $urandom);
						default: stall_pat = 16'($urandom & $urandom);
					endcase
					if (stall_pat == 16'h0000)
						stall_pat[0] = 1'b1;
					pat_age = 48;
				end
				pat_age--;
				take      = stall_pat[0];
				stall_pat = {stall_pat[0], stall_pat[15:1]};
			end
			rsp_bus.ready <= take;
		end
	end

	// Give up on a hung run
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		req_bus.valid        = 1'b0;
		req_bus.req_type     = REQ_PEEK;
		req_bus.zone_id      = '0;
		req_bus.due_time     = '0;
		req_bus.task_kind    = '0;
		req_bus.zone_busy    = 1'b0;
		req_bus.current_time = '0;
		rsp_bus.ready        = 1'b0;
		hold_kick            = 1'b0;
		stim_done            = 1'b0;
		mismatch_cnt         = 0;
		sent_cnt             = 0;
		rsp_cnt              = 0;
		clock_now            = '0;
		sched_pct            = 40;
		random_built         = 0;
		for (int i = 0; i < CAPACITY; i++) begin
			slot_live[i]    = 1'b0;
			slot_flushed[i] = 1'b0;
			slot_due[i]     = '0;
			slot_zone[i]    = '0;
			slot_kind[i]    = '0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// drain every outstanding result, then watch for strays
		wait (stim_done);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
